// ----- hw/rtl/wheel_odometry_ema_defines.svh -----
// -----------------------------------------------------------------------------
// Wheel odometry assertion macros
// Short forms for the concurrent checks used in the odometry RTL.
// -----------------------------------------------------------------------------
`ifndef WHEEL_ODOMETRY_EMA_DEFINES_SVH
`define WHEEL_ODOMETRY_EMA_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define WODO_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define WODO_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define WODO_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/wodo_pkg.sv -----
// -----------------------------------------------------------------------------
// Wheel odometry package
// Widths, constants and the control and status types shared by the modules.
// -----------------------------------------------------------------------------
package wodo_pkg;

   localparam int CNT_W   = 32;
   localparam int DT_W    = 20;
   localparam int CM_W    = 24;
   localparam int ALPHA_W = 17;
   localparam int DIST_W  = 64;
   localparam int SPD_W   = 48;
   localparam int MAG_W   = CNT_W + CM_W;      // magnitude of one distance step
   localparam int NUM_W   = MAG_W + DT_W;      // magnitude times microseconds per second

   localparam int MUL_STEPS = CM_W;
   localparam int SCL_STEPS = DT_W;
   localparam int DIV_STEPS = SPD_W;
   localparam int EMA_STEPS = ALPHA_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [DT_W-1:0]    US_PER_S = 20'd1000000;
   localparam logic [ALPHA_W-1:0] ONE_Q16  = 17'h10000;
   localparam logic [SPD_W-1:0]   SPD_MAX  = 48'h7FFF_FFFF_FFFF;
   localparam logic [SPD_W-1:0]   SPD_MIN  = 48'h8000_0000_0000;

   localparam logic [CM_W-1:0]    CM_RESET    = 24'd65536;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd19661;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = CM_W;
   localparam logic [CSR_IDX_W-1:0] CSR_CM_PER_PULSE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMA_ALPHA_NEW = 1'd1;

   typedef struct packed {
      logic               start;
      logic [DT_W-1:0]    dt;
      logic [CM_W-1:0]    cm;
      logic [ALPHA_W-1:0] alpha;
   } wodo_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } wodo_sts_type;

endpackage

// ----- hw/rtl/wheel_odometry_ema.sv -----
// -----------------------------------------------------------------------------
// Wheel odometry with filtered speed
// Differential encoder odometry: running wheel distances, their mean and
// moving-average filtered wheel speeds, one result per input item.
// -----------------------------------------------------------------------------
// Usage:
//   The req_ channel brings both encoder counts and the elapsed time in
//   microseconds; the rsp_ channel returns the updated flag, both distances,
//   the total distance and both filtered speeds. The csr_ channel writes the
//   cm-per-pulse and alpha registers; write it only while no item is pending.
//   An item with nonzero time runs both wheels side by side through a
//   bit-serial multiply, a bit-serial scaling, a restoring division with
//   one quotient bit per cycle and a bit-serial filter multiply. Its result
//   is loaded into the output register in the send state, and only then is
//   the next item taken. An item with zero time skips the lanes and reports
//   the held state. Only one item is in flight; req_stall is high meanwhile.
//   Reset clears all distances, speeds and previous counts and restores the
//   register defaults. While rsp_stall is high the result is held, and a
//   finished item waits for the output register to free up.
// -----------------------------------------------------------------------------
`include "wheel_odometry_ema_defines.svh"

module wheel_odometry_ema
   import wodo_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [CNT_W-1:0]   req_count_left,
   input  logic signed [CNT_W-1:0]   req_count_right,
   input  logic [DT_W-1:0]           req_dt_us,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_updated,
   output logic signed [DIST_W-1:0]  rsp_distance_left,
   output logic signed [DIST_W-1:0]  rsp_distance_right,
   output logic signed [DIST_W-1:0]  rsp_total_distance,
   output logic signed [SPD_W-1:0]   rsp_speed_left,
   output logic signed [SPD_W-1:0]   rsp_speed_right,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [1:0] {T_IDLE, T_RUN, T_SEND} top_state_type;

   top_state_type       state_ff;
   logic [DT_W-1:0]     dt_ff;
   logic                upd_ff;
   logic [CM_W-1:0]     cm_ff;
   logic [ALPHA_W-1:0]  alpha_ff;
   logic                rsp_valid_ff;
   logic                rsp_updated_ff;
   logic [DIST_W-1:0]   rsp_dist_l_ff;
   logic [DIST_W-1:0]   rsp_dist_r_ff;
   logic [DIST_W-1:0]   rsp_total_ff;
   logic [SPD_W-1:0]    rsp_speed_l_ff;
   logic [SPD_W-1:0]    rsp_speed_r_ff;

   wodo_ctl_type        ctl;
   wodo_sts_type        sts_l;
   wodo_sts_type        sts_r;
   logic [DIST_W-1:0]   dist_l;
   logic [DIST_W-1:0]   dist_r;
   logic [SPD_W-1:0]    speed_l;
   logic [SPD_W-1:0]    speed_r;
   logic                req_accept;
   logic                rsp_free;
   logic [DIST_W:0]     dist_sum;

   assign req_stall  = reset || (state_ff != T_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = !reset;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign ctl.start = req_accept && (req_dt_us != '0);
   assign ctl.dt    = dt_ff;
   assign ctl.cm    = cm_ff;
   assign ctl.alpha = alpha_ff;

   wodo_lane u_lane_left (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .count    (req_count_left),
      .sts      (sts_l),
      .distance (dist_l),
      .speed    (speed_l)
   );

   wodo_lane u_lane_right (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .count    (req_count_right),
      .sts      (sts_r),
      .distance (dist_r),
      .speed    (speed_r)
   );

   // Exact 65-bit sum, so the halved total is the floored mean.
   assign dist_sum = {dist_l[DIST_W-1], dist_l} + {dist_r[DIST_W-1], dist_r};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         cm_ff        <= CM_RESET;
         alpha_ff     <= ALPHA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CM_PER_PULSE:  cm_ff    <= csr_wdata[CM_W-1:0];
               CSR_EMA_ALPHA_NEW: alpha_ff <= csr_wdata[ALPHA_W-1:0];
               default: begin
               end
            endcase
         end

         // A new result loaded in the send state takes precedence over clearing.
         if (rsp_valid_ff && !rsp_stall && (state_ff != T_SEND)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            T_IDLE: begin
               if (req_accept) begin
                  dt_ff    <= req_dt_us;
                  upd_ff   <= (req_dt_us != '0);
                  state_ff <= (req_dt_us != '0) ? T_RUN : T_SEND;
               end
            end
            T_RUN: begin
               if (sts_l.done) begin
                  state_ff <= T_SEND;
               end
            end
            T_SEND: begin
               if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_updated_ff <= upd_ff;
                  rsp_dist_l_ff  <= dist_l;
                  rsp_dist_r_ff  <= dist_r;
                  rsp_total_ff   <= dist_sum[DIST_W:1];
                  rsp_speed_l_ff <= speed_l;
                  rsp_speed_r_ff <= speed_r;
                  state_ff       <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_updated        = rsp_updated_ff;
   assign rsp_distance_left  = rsp_dist_l_ff;
   assign rsp_distance_right = rsp_dist_r_ff;
   assign rsp_total_distance = rsp_total_ff;
   assign rsp_speed_left     = rsp_speed_l_ff;
   assign rsp_speed_right    = rsp_speed_r_ff;

   `WODO_ASSERT_ALWAYS(a_lanes_in_step, (sts_l.done == sts_r.done) && (sts_l.busy == sts_r.busy), "wheel lanes out of step")
   `WODO_ASSERT_IMPL(a_start_from_idle, ctl.start, state_ff == T_IDLE, "lane start outside idle")
   `WODO_ASSERT_NEXT(a_skip_holds_state, req_accept && (req_dt_us == '0), $stable(dist_l) && $stable(dist_r) && $stable(speed_l) && $stable(speed_r), "state changed on a skipped item")

endmodule

// ----- hw/rtl/wodo_lane.sv -----
// -----------------------------------------------------------------------------
// Wheel odometry lane
// One wheel: count delta, bit-serial scaling, distance accumulation, bit-serial
// speed division with saturation and a bit-serial moving-average filter.
// -----------------------------------------------------------------------------
`include "wheel_odometry_ema_defines.svh"

module wodo_lane
   import wodo_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  wodo_ctl_type             ctl,
   input  logic signed [CNT_W-1:0]  count,
   output wodo_sts_type             sts,
   output logic signed [DIST_W-1:0] distance,
   output logic signed [SPD_W-1:0]  speed
);

   typedef enum logic [3:0] {
      L_IDLE, L_MUL, L_SCL, L_DSET, L_DIV, L_RAW, L_DIFF, L_EMA, L_FIN
   } lane_state_type;

   lane_state_type      state_ff;
   logic [STEP_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]    prev_ff;
   logic                neg_ff;
   logic [CNT_W-1:0]    md_ff;
   logic [MAG_W-1:0]    mul_ff;   // {partial sum, remaining multiplier bits}
   logic [NUM_W-1:0]    scl_ff;
   logic                ovf_ff;
   logic [DT_W-1:0]     rem_ff;
   logic [SPD_W-1:0]    quo_ff;   // dividend bits shift out, quotient bits shift in
   logic [SPD_W-1:0]    raw_ff;
   logic [SPD_W:0]      diff_ff;
   logic [SPD_W+2+ALPHA_W-1:0] ema_ff;
   logic [DIST_W-1:0]   dist_ff;
   logic [SPD_W-1:0]    speed_ff;

   logic [CNT_W-1:0]    delta;
   logic [CNT_W-1:0]    mag_delta;
   logic [CNT_W:0]      mul_sum;
   logic [MAG_W:0]      scl_sum;
   logic [DIST_W-1:0]   step_dist;
   logic                ovf_in;
   logic [DT_W:0]       div_trial;
   logic                div_ge;
   logic [DT_W:0]       div_diff;
   logic                pos_sat;
   logic                neg_sat;
   logic [SPD_W-1:0]    raw_in;
   logic [SPD_W:0]      diff_in;
   logic [ALPHA_W-1:0]  alpha_clamped;
   logic [SPD_W+1:0]    ema_sum;

   assign delta     = count - prev_ff;
   assign mag_delta = delta[CNT_W-1] ? -delta : delta;

   assign mul_sum = {1'b0, mul_ff[MAG_W-1:CM_W]} + (mul_ff[0] ? {1'b0, md_ff} : '0);
   assign scl_sum = {1'b0, scl_ff[NUM_W-1:DT_W]} + (scl_ff[0] ? {1'b0, mul_ff} : '0);

   assign step_dist = neg_ff ? -{{(DIST_W-MAG_W){1'b0}}, mul_ff}
                             :  {{(DIST_W-MAG_W){1'b0}}, mul_ff};

   // The quotient fits in 48 bits only if the part of the dividend above them
   // is already smaller than the divisor.
   assign ovf_in = scl_ff[NUM_W-1:SPD_W] >= {{(NUM_W-SPD_W-DT_W){1'b0}}, ctl.dt};

   assign div_trial = {rem_ff, quo_ff[SPD_W-1]};
   assign div_ge    = div_trial >= {1'b0, ctl.dt};
   assign div_diff  = div_trial - {1'b0, ctl.dt};

   assign pos_sat = ovf_ff || quo_ff[SPD_W-1];
   assign neg_sat = ovf_ff || (quo_ff[SPD_W-1] && (|quo_ff[SPD_W-2:0]));
   assign raw_in  = neg_ff ? (neg_sat ? SPD_MIN : -quo_ff)
                           : (pos_sat ? SPD_MAX : quo_ff);

   // new = old + floor((raw - old) * alpha / 2^16), same as the weighted form.
   assign diff_in       = {raw_ff[SPD_W-1], raw_ff} - {speed_ff[SPD_W-1], speed_ff};
   assign alpha_clamped = (ctl.alpha > ONE_Q16) ? ONE_Q16 : ctl.alpha;
   assign ema_sum = ema_ff[SPD_W+2+ALPHA_W-1:ALPHA_W]
                  + (ema_ff[0] ? {diff_ff[SPD_W], diff_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         cnt_ff   <= '0;
         prev_ff  <= '0;
         dist_ff  <= '0;
         speed_ff <= '0;
      end else begin
         case (state_ff)
            L_IDLE: begin
               if (ctl.start) begin
                  prev_ff  <= count;
                  neg_ff   <= delta[CNT_W-1];
                  md_ff    <= mag_delta;
                  mul_ff   <= {{CNT_W{1'b0}}, ctl.cm};
                  cnt_ff   <= '0;
                  state_ff <= L_MUL;
               end
            end
            L_MUL: begin
               mul_ff <= {mul_sum, mul_ff[CM_W-1:1]};
               if (cnt_ff == STEP_W'(MUL_STEPS - 1)) begin
                  scl_ff   <= {{MAG_W{1'b0}}, US_PER_S};
                  cnt_ff   <= '0;
                  state_ff <= L_SCL;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            L_SCL: begin
               scl_ff <= {scl_sum, scl_ff[DT_W-1:1]};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == STEP_W'(SCL_STEPS - 1)) begin
                  state_ff <= L_DSET;
               end
            end
            L_DSET: begin
               ovf_ff   <= ovf_in;
               rem_ff   <= scl_ff[SPD_W+DT_W-1:SPD_W];
               quo_ff   <= scl_ff[SPD_W-1:0];
               dist_ff  <= dist_ff + step_dist;
               cnt_ff   <= '0;
               state_ff <= L_DIV;
            end
            L_DIV: begin
               rem_ff <= div_ge ? div_diff[DT_W-1:0] : div_trial[DT_W-1:0];
               quo_ff <= {quo_ff[SPD_W-2:0], div_ge};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
                  state_ff <= L_RAW;
               end
            end
            L_RAW: begin
               raw_ff   <= raw_in;
               state_ff <= L_DIFF;
            end
            L_DIFF: begin
               diff_ff  <= diff_in;
               ema_ff   <= {{(SPD_W+2){1'b0}}, alpha_clamped};
               cnt_ff   <= '0;
               state_ff <= L_EMA;
            end
            L_EMA: begin
               ema_ff <= {ema_sum[SPD_W+1], ema_sum, ema_ff[ALPHA_W-1:1]};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == STEP_W'(EMA_STEPS - 1)) begin
                  state_ff <= L_FIN;
               end
            end
            L_FIN: begin
               speed_ff <= speed_ff + ema_ff[SPD_W+ALPHA_W-2:ALPHA_W-1];
               state_ff <= L_IDLE;
            end
            default: begin
               state_ff <= L_IDLE;
            end
         endcase
      end
   end

   assign sts.busy = (state_ff != L_IDLE);
   assign sts.done = (state_ff == L_FIN);
   assign distance = dist_ff;
   assign speed    = speed_ff;

   `WODO_ASSERT_IMPL(a_start_when_idle, ctl.start, state_ff == L_IDLE, "lane started while busy")
   `WODO_ASSERT_IMPL(a_div_rem_bound, (state_ff == L_DIV) && !ovf_ff, rem_ff < ctl.dt, "remainder not below divisor")
   `WODO_ASSERT_IMPL(a_div_count, state_ff == L_DIV, cnt_ff < STEP_W'(DIV_STEPS), "division ran past its steps")

endmodule

// ----- tb/wheel_odometry_ema_tb.sv -----
// -----------------------------------------------------------------------------
// Wheel odometry testbench
// Drives encoder samples through the req_ channel under random sender and
// receiver idling, tracks distances and filtered speeds in a local odometry
// model, and compares every rsp_ item field by field in arrival order.
// -----------------------------------------------------------------------------
module wheel_odometry_ema_tb;
   import wodo_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 240;
   localparam int HOLD_CYCLES = 600;

   typedef struct {
      logic signed [CNT_W-1:0] cl;
      logic signed [CNT_W-1:0] cr;
      logic [DT_W-1:0]         dt;
   } sample_type;

   typedef struct {
      logic                     upd;
      logic signed [DIST_W-1:0] dl;
      logic signed [DIST_W-1:0] dr;
      logic signed [DIST_W-1:0] tot;
      logic signed [SPD_W-1:0]  sl;
      logic signed [SPD_W-1:0]  sr;
   } report_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [CNT_W-1:0]  req_count_left = '0;
   logic signed [CNT_W-1:0]  req_count_right = '0;
   logic [DT_W-1:0]          req_dt_us = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_updated;
   logic signed [DIST_W-1:0] rsp_distance_left;
   logic signed [DIST_W-1:0] rsp_distance_right;
   logic signed [DIST_W-1:0] rsp_total_distance;
   logic signed [SPD_W-1:0]  rsp_speed_left;
   logic signed [SPD_W-1:0]  rsp_speed_right;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_CM_PER_PULSE;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   // Local copy of the odometry state and registers.
   logic [CM_W-1:0]          cm_reg    = CM_RESET;
   logic [ALPHA_W-1:0]       alpha_reg = ALPHA_RESET;
   logic signed [CNT_W-1:0]  last_cl   = '0;
   logic signed [CNT_W-1:0]  last_cr   = '0;
   logic signed [DIST_W-1:0] dist_l    = '0;
   logic signed [DIST_W-1:0] dist_r    = '0;
   logic signed [SPD_W-1:0]  spd_l     = '0;
   logic signed [SPD_W-1:0]  spd_r     = '0;

   sample_type encoder_samples[$];
   report_type odo_reports_due[$];
   int      bad_reports = 0;
   int      send_gap = 0;
   int      recv_gap = 0;
   bit      idle_on = 1'b0;
   bit      hold_go = 1'b0;
   logic    rsp_hold = 1'b0;

   wheel_odometry_ema dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_count_left     (req_count_left),
      .req_count_right    (req_count_right),
      .req_dt_us          (req_dt_us),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_updated        (rsp_updated),
      .rsp_distance_left  (rsp_distance_left),
      .rsp_distance_right (rsp_distance_right),
      .rsp_total_distance (rsp_total_distance),
      .rsp_speed_left     (rsp_speed_left),
      .rsp_speed_right    (rsp_speed_right),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #2 clock = ~clock;

   // Distance step times one million over dt, truncated toward zero and
   // clamped to the 48-bit speed range.
   function automatic logic signed [SPD_W-1:0] raw_rate(logic signed [DIST_W-1:0] d,
                                                       logic [DT_W-1:0] dt);
      logic signed [127:0] quo;
      quo = (128'(d) * $signed(128'(US_PER_S))) / $signed(128'(dt));
      if (quo > 128'sd140737488355327)
         return SPD_MAX;
      if (quo < -128'sd140737488355328)
         return SPD_MIN;
      return quo[SPD_W-1:0];
   endfunction

   function automatic logic signed [SPD_W-1:0] ema_filter(logic signed [SPD_W-1:0] held,
                                                         logic signed [SPD_W-1:0] fresh);
      logic [ALPHA_W-1:0] a;
      logic signed [80:0] mix;
      a = (alpha_reg > ONE_Q16) ? ONE_Q16 : alpha_reg;
      mix = 81'(held) * $signed(81'(ONE_Q16 - a)) + 81'(fresh) * $signed(81'(a));
      mix = mix >>> 16;
      return mix[SPD_W-1:0];
   endfunction

   function automatic report_type advance_odometry(sample_type s);
      logic signed [CNT_W-1:0]  dcl;
      logic signed [CNT_W-1:0]  dcr;
      logic signed [DIST_W-1:0] step_l;
      logic signed [DIST_W-1:0] step_r;
      logic signed [DIST_W:0]   pair_sum;
      report_type r;
      if (s.dt != '0) begin
         dcl = s.cl - last_cl;
         dcr = s.cr - last_cr;
         step_l = DIST_W'(dcl) * $signed(DIST_W'(cm_reg));
         step_r = DIST_W'(dcr) * $signed(DIST_W'(cm_reg));
         last_cl = s.cl;
         last_cr = s.cr;
         dist_l = dist_l + step_l;
         dist_r = dist_r + step_r;
         spd_l = ema_filter(spd_l, raw_rate(step_l, s.dt));
         spd_r = ema_filter(spd_r, raw_rate(step_r, s.dt));
      end
      pair_sum = {dist_l[DIST_W-1], dist_l} + {dist_r[DIST_W-1], dist_r};
      r.upd = (s.dt != '0);
      r.dl  = dist_l;
      r.dr  = dist_r;
      r.tot = pair_sum[DIST_W:1];
      r.sl  = spd_l;
      r.sr  = spd_r;
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 'h%h, actual 'h%h", $time, name, want, got);
         bad_reports++;
      end
   endtask

   // Sender: offers the head of the sample queue, holds it while stalled.
   always @(posedge clock) begin : drive_samples
      logic held;
      held = req_valid && req_stall;
      if (!reset) begin
         if (req_valid && !req_stall)
            odo_reports_due.push_back(advance_odometry(encoder_samples.pop_front()));
         if (!held) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (encoder_samples.size() != 0) begin
               if (idle_on && $urandom_range(0, 3) == 0) begin
                  send_gap = $urandom_range(0, 8);
                  req_valid <= 1'b0;
               end else begin
                  req_valid       <= 1'b1;
                  req_count_left  <= encoder_samples[0].cl;
                  req_count_right <= encoder_samples[0].cr;
                  req_dt_us       <= encoder_samples[0].dt;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each accepted item against the oldest prediction.
   always @(posedge clock) begin : watch_reports
      report_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (odo_reports_due.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual updated=%b",
                        $time, rsp_updated);
               bad_reports++;
            end else begin
               want = odo_reports_due.pop_front();
               check_field("updated", 64'(want.upd), 64'(rsp_updated));
               check_field("distance_left", want.dl, rsp_distance_left);
               check_field("distance_right", want.dr, rsp_distance_right);
               check_field("total_distance", want.tot, rsp_total_distance);
               check_field("speed_left", 64'(want.sl[SPD_W-1:0]),
                           64'(rsp_speed_left[SPD_W-1:0]));
               check_field("speed_right", 64'(want.sr[SPD_W-1:0]),
                           64'(rsp_speed_right[SPD_W-1:0]));
            end
         end
         if (rsp_hold) begin
            rsp_stall <= 1'b1;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            recv_gap = $urandom_range(0, 8);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // One long receiver hold-off so that the block backs up into the sender.
   initial begin : long_hold
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #8_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      logic [CM_W-1:0]         cm_pick[PHASES];
      logic [ALPHA_W-1:0]      alpha_pick[PHASES];
      logic signed [CNT_W-1:0] cur_l;
      logic signed [CNT_W-1:0] cur_r;
      sample_type              s;
      int                      roll;
      int                      span;

      cm_pick    = '{24'd65536, 24'hFFFFFF, 24'd1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd65536};
      alpha_pick = '{17'd19661, 17'd0, 17'h1FFFF, 17'd0, 17'd65536, 17'd1, 17'd0, 17'd70000};
      cm_pick[3]    = CM_W'($urandom_range(0, 24'hFFFFFF));
      cm_pick[5]    = CM_W'($urandom_range(1000, 400000));
      cm_pick[6]    = CM_W'($urandom_range(0, 24'hFFFFFF));
      alpha_pick[3] = ALPHA_W'($urandom_range(0, 65536));
      alpha_pick[6] = ALPHA_W'($urandom_range(0, 17'h1FFFF));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items under the reset register values.
      push_sample(0, 0, 0);
      push_sample(1000, -1000, 1000);
      push_sample(1000, -1000, 1);
      push_sample(32'sh7FFFFFFF, 32'sh80000000, 1);
      push_sample(32'sh80000000, 32'sh7FFFFFFF, 1000000);
      push_sample(5, 7, 0);
      push_sample(10, -10, 20'hFFFFF);
      push_sample(-50000, 50000, 1);
      push_sample(-1, -1, 500);
      push_sample(0, 0, 0);
      drain();

      // Largest scale with the filter passing raw speed straight through.
      write_regs(24'hFFFFFF, ONE_Q16);
      push_sample(32'sh7FFFFFFF, 32'sh80000000, 1);
      push_sample(32'sh80000001, 32'sh7FFFFFFF, 1000000);
      push_sample(32'sh80000001, 32'sh7FFFFFFF, 0);
      push_sample(0, 0, 20'hFFFFF);
      push_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 3);
      drain();

      // Zero scale and zero filter weight: no distance or speed may move.
      write_regs(24'd0, 17'd0);
      push_sample(123456, -654321, 77);
      push_sample(0, 0, 1);
      push_sample(-9, 9, 0);
      drain();

      cur_l = last_cl;
      cur_r = last_cr;
      for (int ph = 0; ph < PHASES; ph++) begin
         write_regs(cm_pick[ph], alpha_pick[ph]);
         idle_on = (ph % 3 != 1) && (ph != PHASES - 1);
         if (ph == 2)
            hold_go = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               // Zero time: counts are ignored and the tracked counts stay.
               s.cl = $urandom();
               s.cr = $urandom();
               s.dt = '0;
            end else if (roll < 82) begin
               case ($urandom_range(0, 2))
                  0:       span = 1000;
                  1:       span = 1 << 16;
                  default: span = 1 << 24;
               endcase
               cur_l = cur_l + (int'($urandom_range(0, 2 * span)) - span);
               cur_r = cur_r + (int'($urandom_range(0, 2 * span)) - span);
               s.cl = cur_l;
               s.cr = cur_r;
               s.dt = ($urandom_range(0, 1) != 0) ? DT_W'($urandom_range(1, 2000))
                                                   : DT_W'($urandom_range(1, 1000000));
            end else begin
               cur_l = $urandom();
               cur_r = $urandom();
               s.cl = cur_l;
               s.cr = cur_r;
               s.dt = ($urandom_range(0, 3) == 0) ? 20'd1
                                                   : DT_W'($urandom_range(1, 20'hFFFFF));
            end
            encoder_samples.push_back(s);
         end
         // The sender stays quiet until every result of the phase is back.
         drain();
      end

      repeat (200) @(posedge clock);
      if (bad_reports == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   task automatic push_sample(logic signed [CNT_W-1:0] cl, logic signed [CNT_W-1:0] cr,
                              logic [DT_W-1:0] dt);
      sample_type s;
      s.cl = cl;
      s.cr = cr;
      s.dt = dt;
      encoder_samples.push_back(s);
   endtask

   task automatic drain();
      while (encoder_samples.size() != 0 || odo_reports_due.size() != 0)
         @(posedge clock);
   endtask

   // Writes both registers back to back; valid stays high between them.
   task automatic write_regs(logic [CM_W-1:0] cm, logic [ALPHA_W-1:0] alpha);
      csr_valid <= 1'b1;
      csr_index <= CSR_CM_PER_PULSE;
      csr_wdata <= cm;
      do @(posedge clock); while (!csr_ready);
      cm_reg = cm;
      csr_index <= CSR_EMA_ALPHA_NEW;
      csr_wdata <= CSR_DATA_W'(alpha);
      do @(posedge clock); while (!csr_ready);
      alpha_reg = alpha;
      csr_valid <= 1'b0;
   endtask

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/wodo_pkg.sv
hw/rtl/wodo_lane.sv
hw/rtl/wheel_odometry_ema.sv
tb/wheel_odometry_ema_tb.sv
